FILE: design/ecr_pkg.sv
// Shared types, constants and tables for the Euler z-x-z rotation core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ecr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = 5;                  // holds stage numbers up to 31
    localparam int ANG_W         = 16;                 // Q3.13 angle register
    localparam int IDX_W         = 2;                  // configuration register index
    localparam int COMP_W        = 24;                 // Q9.15 component on the ports
    localparam int VW            = 26;                 // internal component, unclipped
    localparam int CX_W          = 27;                 // CORDIC x/y, Q24
    localparam int CZ_W          = 28;                 // CORDIC residual angle, Q24
    localparam int PR_W          = VW + CX_W;          // one product
    localparam int SUM_W         = PR_W + 1;           // sum of two products
    localparam int LATENCY       = CORDIC_STAGES + 8;  // start edge to done cycle

    localparam logic [IDX_W-1:0] REG_ANGLE_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] REG_ANGLE_THIRD  = 2'd2;
    localparam logic [IDX_W-1:0] REG_INVERSE_MODE = 2'd3;

    localparam logic [ANG_W-1:0] ANGLE_FIRST_RST  = 16'd4729;
    localparam logic [ANG_W-1:0] ANGLE_SECOND_RST = 16'd13255;
    localparam logic [ANG_W-1:0] ANGLE_THIRD_RST  = 16'd22268;

    localparam logic signed [CX_W-1:0] GAIN_Q24    = 27'sd10188014;
    localparam logic signed [CZ_W-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd8388608);

    localparam logic signed [VW-1:0] COMP_MAX = 26'sd8388607;
    localparam logic signed [VW-1:0] COMP_MIN = -26'sd8388608;

    // word moving down the CORDIC chain: vector plus three sin/cos generators
    typedef struct packed {
        logic                      vld;
        logic                      inv;
        logic [2:0]                neg;
        logic [2:0][CX_W-1:0]      cx;
        logic [2:0][CX_W-1:0]      cy;
        logic [2:0][CZ_W-1:0]      cz;
        logic [2:0][VW-1:0]        v;
    } cord_t;

    // word moving down the rotation chain: vector plus ordered cos/sin pairs
    typedef struct packed {
        logic                      vld;
        logic [2:0][VW-1:0]        v;
        logic [2:0][CX_W-1:0]      c;
        logic [2:0][CX_W-1:0]      s;
    } rot_t;

    function automatic logic signed [CZ_W-1:0] atan_q24(input logic [STAGE_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        case (i)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            5'd20:   r = 28'sd16;
            5'd21:   r = 28'sd8;
            5'd22:   r = 28'sd4;
            5'd23:   r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/ecr_cordic_cell.sv
// One CORDIC iteration for all three angles, registered.
// Depends on ecr_pkg.
`timescale 1ns / 1ps
module ecr_cordic_cell
    import ecr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [STAGE_W-1:0] stage,
    input  cord_t              din,
    output cord_t              dout
);

    cord_t                  dout_next;
    logic signed [CZ_W-1:0] atn;

    always_comb
    begin
        logic signed [CX_W-1:0] x, y, xs, ys;
        logic signed [CZ_W-1:0] z;
        atn       = atan_q24(stage);
        dout_next = din;
        for (int k = 0; k < 3; k++)
        begin
            x  = $signed(din.cx[k]);
            y  = $signed(din.cy[k]);
            z  = $signed(din.cz[k]);
            xs = x >>> stage;
            ys = y >>> stage;
            if (z >= 0)
            begin
                dout_next.cx[k] = x - ys;
                dout_next.cy[k] = y + xs;
                dout_next.cz[k] = z - atn;
            end
            else
            begin
                dout_next.cx[k] = x + ys;
                dout_next.cy[k] = y - xs;
                dout_next.cz[k] = z + atn;
            end
        end
    end

    cord_t dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

FILE: design/ecr_rot_cell.sv
// One plane rotation a' = c*a + s*b, b' = c*b - s*a over two register stages.
// Depends on ecr_pkg.
`timescale 1ns / 1ps
module ecr_rot_cell
    import ecr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             plane_yz,   // 0: (x,y), 1: (y,z)
    input  logic [IDX_W-1:0] pair,       // which cos/sin pair to use
    input  rot_t             din,
    output rot_t             dout
);

    logic signed [VW-1:0]   a, b;
    logic signed [CX_W-1:0] c, s;

    assign a = plane_yz ? $signed(din.v[1]) : $signed(din.v[0]);
    assign b = plane_yz ? $signed(din.v[2]) : $signed(din.v[1]);
    assign c = $signed(din.c[pair]);
    assign s = $signed(din.s[pair]);

    // stage A: products
    rot_t                   st_reg;
    logic signed [PR_W-1:0] ca_reg, sb_reg, cb_reg, sa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= din;
    end

    always_ff @(posedge clk)
    begin
        ca_reg   <= PR_W'(c) * PR_W'(a);
        sb_reg   <= PR_W'(s) * PR_W'(b);
        cb_reg   <= PR_W'(c) * PR_W'(b);
        sa_reg   <= PR_W'(s) * PR_W'(a);
    end

    // stage B: sum and round half up to Q15
    logic signed [SUM_W-1:0] na_sum, nb_sum;
    logic signed [SUM_W-1:0] na_sh, nb_sh;
    rot_t                    dout_next;

    always_comb
    begin
        na_sum    = SUM_W'(ca_reg) + SUM_W'(sb_reg) + ROUND_HALF;
        nb_sum    = SUM_W'(cb_reg) - SUM_W'(sa_reg) + ROUND_HALF;
        na_sh     = na_sum >>> 24;
        nb_sh     = nb_sum >>> 24;
        dout_next = st_reg;
        if (plane_yz)
        begin
            dout_next.v[1] = na_sh[VW-1:0];
            dout_next.v[2] = nb_sh[VW-1:0];
        end
        else
        begin
            dout_next.v[0] = na_sh[VW-1:0];
            dout_next.v[1] = nb_sh[VW-1:0];
        end
    end

    rot_t dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

FILE: design/euler_zxz_vector_rotation_core.sv
// Top level: Euler z-x-z vector rotation, CORDIC chain followed by three rotation cells.
// Depends on ecr_pkg, ecr_cordic_cell, ecr_rot_cell.
//
// Usage:
//   Input: drive vec_x/vec_y/vec_z and pulse start; busy never rises, so a word is
//   taken at every clock edge where start is high. One word per cycle sustained.
//   Output: done is high for one cycle with rot_x/rot_y/rot_z and saturated; there is
//   no backpressure, results leave in input order.
//   Pipeline: an input register, one CORDIC cell per stage, a multiply register and
//   a sum-and-round register for each plane rotation, and the output clip register.
//   Throughput is one word per clock; the CORDIC chain runs the sin/cos of all three
//   angles beside each word, so the angles travel with the vector.
//   Configuration: wr_en/wr_index/wr_data write angle_first (0), angle_second (1),
//   angle_third (2) and inverse_mode (3); only while no word is in flight.
//   Reset: rst_n clears the pipeline valids and loads the default angles, forward mode.
`timescale 1ns / 1ps
module euler_zxz_vector_rotation_core
    import ecr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_index,
    input  logic [ANG_W-1:0]         wr_data,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COMP_W-1:0] vec_x,
    input  logic signed [COMP_W-1:0] vec_y,
    input  logic signed [COMP_W-1:0] vec_z,
    output logic                     done,
    output logic signed [COMP_W-1:0] rot_x,
    output logic signed [COMP_W-1:0] rot_y,
    output logic signed [COMP_W-1:0] rot_z,
    output logic                     saturated
);

    logic [ANG_W-1:0] angle_first_reg, angle_second_reg, angle_third_reg;
    logic             inverse_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_first_reg  <= ANGLE_FIRST_RST;
            angle_second_reg <= ANGLE_SECOND_RST;
            angle_third_reg  <= ANGLE_THIRD_RST;
            inverse_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ANGLE_FIRST:  angle_first_reg  <= wr_data;
                REG_ANGLE_SECOND: angle_second_reg <= wr_data;
                REG_ANGLE_THIRD:  angle_third_reg  <= wr_data;
                REG_INVERSE_MODE: inverse_mode_reg <= wr_data[0];
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input cell: fold angles into [-pi/2, pi/2] and seed the CORDIC
    cord_t cord [0:CORDIC_STAGES];
    cord_t in_next;

    always_comb
    begin
        logic [2:0][ANG_W-1:0]  ang;
        logic signed [CZ_W-1:0] z;
        ang[0] = angle_first_reg;
        ang[1] = angle_second_reg;
        ang[2] = angle_third_reg;
        in_next.vld = start & ~busy;
        in_next.inv = inverse_mode_reg;
        in_next.v[0] = VW'(vec_x);
        in_next.v[1] = VW'(vec_y);
        in_next.v[2] = VW'(vec_z);
        for (int k = 0; k < 3; k++)
        begin
            z = CZ_W'($signed(ang[k])) <<< 11;
            in_next.neg[k] = 1'b0;
            if (z > HALF_PI_Q24)
            begin
                z = z - PI_Q24;
                in_next.neg[k] = 1'b1;
            end
            else if (z < -HALF_PI_Q24)
            begin
                z = z + PI_Q24;
                in_next.neg[k] = 1'b1;
            end
            in_next.cz[k] = z;
            in_next.cx[k] = GAIN_Q24;
            in_next.cy[k] = '0;
        end
    end

    cord_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else
            in_reg <= in_next;
    end

    assign cord[0] = in_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        ecr_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .stage (STAGE_W'(i)),
            .din   (cord[i]),
            .dout  (cord[i+1])
        );
    end

    // order and sign the cos/sin pairs; inverse runs negated angles in reverse
    rot_t rot [0:3];

    always_comb
    begin
        logic [2:0][CX_W-1:0] cc, ss;
        cord_t                ce;
        ce = cord[CORDIC_STAGES];
        for (int k = 0; k < 3; k++)
        begin
            cc[k] = ce.neg[k] ? -$signed(ce.cx[k]) : $signed(ce.cx[k]);
            ss[k] = ce.neg[k] ? -$signed(ce.cy[k]) : $signed(ce.cy[k]);
        end
        rot[0].vld = ce.vld;
        rot[0].v   = ce.v;
        if (ce.inv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rot[0].c[k] = cc[2-k];
                rot[0].s[k] = -$signed(ss[2-k]);
            end
        end
        else
        begin
            rot[0].c = cc;
            rot[0].s = ss;
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_rot
        ecr_rot_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .plane_yz (r == 1),
            .pair     (IDX_W'(r)),
            .din      (rot[r]),
            .dout     (rot[r+1])
        );
    end

    // output clip
    logic                     done_reg;
    logic signed [COMP_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic                     saturated_reg;
    logic [2:0][COMP_W-1:0]   clip_next;
    logic [2:0]               hit_next;

    always_comb
    begin
        logic signed [VW-1:0] v;
        for (int k = 0; k < 3; k++)
        begin
            v = $signed(rot[3].v[k]);
            hit_next[k] = 1'b1;
            if (v > COMP_MAX)
                clip_next[k] = COMP_MAX[COMP_W-1:0];
            else if (v < COMP_MIN)
                clip_next[k] = COMP_MIN[COMP_W-1:0];
            else
            begin
                clip_next[k] = v[COMP_W-1:0];
                hit_next[k]  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rot[3].vld;
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg     <= clip_next[0];
        rot_y_reg     <= clip_next[1];
        rot_z_reg     <= clip_next[2];
        saturated_reg <= |hit_next;
    end

    assign done      = done_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z     = rot_z_reg;
    assign saturated = saturated_reg;

    // every accepted word raises done when it leaves the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rot[0].vld |-> ##7 done)
        else $error("rotation chain lost a word");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (rot_x == COMP_MAX[COMP_W-1:0] || rot_x == COMP_MIN[COMP_W-1:0]
            || rot_y == COMP_MAX[COMP_W-1:0] || rot_y == COMP_MIN[COMP_W-1:0]
            || rot_z == COMP_MAX[COMP_W-1:0] || rot_z == COMP_MIN[COMP_W-1:0]))
        else $error("saturated flag without clipped component");

endmodule

FILE: test/tb.sv
// Testbench for euler_zxz_vector_rotation_core: directed vectors, then random vectors
// under many angle settings, checked against a CORDIC-based predictor or a typed-in result.
// Depends on ecr_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
    import ecr_pkg::*;

    localparam int  RAND_PER_PHASE = 160;
    localparam int  N_PHASES       = 9;
    localparam int  CYCLE_LIMIT    = 300000;
    localparam longint LIM_HI      = 8388607;
    localparam longint LIM_LO      = -8388608;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic                     sat;
    } vec_res_t;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        bit                       fixed;   // expected typed in below
        vec_res_t                 res;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [IDX_W-1:0] wr_index = '0;
    logic [ANG_W-1:0] wr_data = '0;
    logic start = 1'b0;
    logic busy;
    logic signed [COMP_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic done;
    logic signed [COMP_W-1:0] rot_x, rot_y, rot_z;
    logic saturated;

    euler_zxz_vector_rotation_core uut (.*);

    always #5 clk = ~clk;

    // angle and mode copies used by the predictor
    logic [ANG_W-1:0] ang [3];
    logic             inv_mode;

    vec_res_t  rot_expected [$];
    vec_res_t  pinned [$];    // typed-in expectation per word, parallel queue
    bit        has_pin [$];
    int        errors = 0;
    int        checked = 0;
    int        cycles = 0;

    function automatic longint atan_tab(input int i);
        longint tbl [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                             262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                             1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return tbl[i];
    endfunction

    function automatic void trig_of(input logic [ANG_W-1:0] a, output longint c,
                                    output longint s);
        longint z, x, y, xs, ys, t;
        bit neg;
        t = longint'($signed(a));
        z = t * 2048;
        neg = 0;
        x = 10188014;
        y = 0;
        if (z > 26353589) begin
            z -= 52707179;
            neg = 1;
        end else if (z < -26353589) begin
            z += 52707179;
            neg = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_tab(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_tab(i));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic void turn_plane(inout longint a, inout longint b,
                                       input longint c, input longint s);
        longint na, nb;
        na = (c * a + s * b + 64'sd8388608) >>> 24;
        nb = (c * b - s * a + 64'sd8388608) >>> 24;
        a = na;
        b = nb;
    endfunction

    function automatic logic signed [COMP_W-1:0] clip_comp(input longint v, inout logic f);
        if (v > LIM_HI) begin
            f = 1'b1;
            return COMP_W'(LIM_HI);
        end
        if (v < LIM_LO) begin
            f = 1'b1;
            return COMP_W'(LIM_LO);
        end
        return COMP_W'(v);
    endfunction

    function automatic vec_res_t rotate_vec(input logic signed [COMP_W-1:0] vx,
                                            input logic signed [COMP_W-1:0] vy,
                                            input logic signed [COMP_W-1:0] vz);
        longint x, y, z;
        longint c [3], s [3];
        vec_res_t r;
        logic f;
        x = vx; y = vy; z = vz;
        for (int k = 0; k < 3; k++) trig_of(ang[k], c[k], s[k]);
        if (inv_mode) begin
            turn_plane(x, y, c[2], -s[2]);
            turn_plane(y, z, c[1], -s[1]);
            turn_plane(x, y, c[0], -s[0]);
        end else begin
            turn_plane(x, y, c[0], s[0]);
            turn_plane(y, z, c[1], s[1]);
            turn_plane(x, y, c[2], s[2]);
        end
        f = 1'b0;
        r.x = clip_comp(x, f);
        r.y = clip_comp(y, f);
        r.z = clip_comp(z, f);
        r.sat = f;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH word %0d %s: got %0d want %0d", checked, what, got, want);
    endtask

    // word acceptance: predict at the accepting edge
    vec_res_t pin_next;
    bit       pin_valid = 0;
    always @(posedge clk) begin
        if (rst_n && start && !busy) begin
            rot_expected.insert(rot_expected.size(), rotate_vec(vec_x, vec_y, vec_z));
            pinned.insert(pinned.size(), pin_next);
            has_pin.insert(has_pin.size(), pin_valid);
        end
    end

    always @(posedge clk) begin
        vec_res_t e, p;
        bit hp;
        if (rst_n && done) begin
            if (rot_expected.size() == 0) begin
                report_mismatch("done with nothing expected", 1, 0);
            end else begin
                e = rot_expected.pop_front();
                p = pinned.pop_front();
                hp = has_pin.pop_front();
                if (hp) e = p;
                if (rot_x !== e.x) report_mismatch("rot_x", rot_x, e.x);
                if (rot_y !== e.y) report_mismatch("rot_y", rot_y, e.y);
                if (rot_z !== e.z) report_mismatch("rot_z", rot_z, e.z);
                if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
                checked++;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_settings(input logic [ANG_W-1:0] a0, input logic [ANG_W-1:0] a1,
                                  input logic [ANG_W-1:0] a2, input logic m);
        logic [ANG_W-1:0] vals [4];
        logic [IDX_W-1:0] idx [4];
        vals = '{a0, a1, a2, ANG_W'(m)};
        idx  = '{REG_ANGLE_FIRST, REG_ANGLE_SECOND, REG_ANGLE_THIRD, REG_INVERSE_MODE};
        for (int k = 0; k < 4; k++) begin
            wr_en <= 1'b1;
            wr_index <= idx[k];
            wr_data <= vals[k];
            @(posedge clk);
        end
        wr_en <= 1'b0;
        ang[0] = a0; ang[1] = a1; ang[2] = a2; inv_mode = m;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (rot_expected.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic send_word(input logic signed [COMP_W-1:0] x,
                             input logic signed [COMP_W-1:0] y,
                             input logic signed [COMP_W-1:0] z);
        start <= 1'b1;
        vec_x <= x; vec_y <= y; vec_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic logic signed [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return COMP_W'(LIM_HI);
            1:       return COMP_W'(LIM_LO);
            2:       return COMP_W'($signed($urandom_range(0, 4000)) - 2000);
            3:       return COMP_W'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return COMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [ANG_W-1:0] rand_angle();
        case ($urandom_range(0, 7))
            0:       return 16'sd25736;
            1:       return -16'sd25736;
            2:       return 16'd12868;                 // just past pi/2, folded
            3:       return -16'sd12868;
            4:       return 16'd12867;
            5:       return 16'd0;
            default: return ANG_W'($urandom);
        endcase
    endfunction

    vec_row_t dir_rows [$];
    int       burst, gap, sent;

    initial begin
        vec_res_t zero_res;
        zero_res = '{x: '0, y: '0, z: '0, sat: 1'b0};
        ang[0] = ANGLE_FIRST_RST; ang[1] = ANGLE_SECOND_RST; ang[2] = ANGLE_THIRD_RST;
        inv_mode = 1'b0;

        dir_rows.insert(dir_rows.size(), '{'0, '0, '0, 1, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh800000, 24'sh800000, 24'sh800000, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh7FFFFF, '0, '0, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{'0, 24'sh7FFFFF, '0, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{'0, '0, 24'sh7FFFFF, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh800000, '0, '0, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{'0, '0, 24'sh800000, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sd1, 24'sd0, 24'sd0, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{-24'sd1, -24'sd1, -24'sd1, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sd32768, 24'sd32768, 24'sd32768, 0, zero_res});
        dir_rows.insert(dir_rows.size(), '{24'sh555555, 24'shAAAAAA, 24'sh555555, 0, zero_res});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset angles, then inverse, then the extreme angles
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                1: write_settings(ANGLE_FIRST_RST, ANGLE_SECOND_RST, ANGLE_THIRD_RST, 1'b1);
                2: write_settings(16'h8000, 16'h8000, 16'h8000, 1'b0);
                3: write_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
                default: ;
            endcase
            foreach (dir_rows[i]) begin
                pin_valid <= dir_rows[i].fixed;
                pin_next <= dir_rows[i].res;
                send_word(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
            end
            pin_valid <= 0;
            wait_drained();
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: write_settings(16'd0, 16'd0, 16'd0, 1'b0);
                1: write_settings(16'sd25736, -16'sd25736, 16'sd25736, 1'b1);
                2: write_settings(-16'sd25736, 16'sd25736, -16'sd25736, 1'b0);
                3: write_settings(16'd12868, 16'd12867, -16'sd12868, 1'b1);
                default: write_settings(rand_angle(), rand_angle(), rand_angle(),
                                        1'($urandom));
            endcase
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
                for (int b = 0; b < burst && sent < RAND_PER_PHASE; b++) begin
                    send_word(rand_comp(), rand_comp(), rand_comp());
                    sent++;
                end
                if (sent == RAND_PER_PHASE / 2 && ph == 4) begin
                    wait_drained();
                end else begin
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 4);
                    if (gap > 0) begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
            wait_drained();
        end

        repeat (LATENCY + 4) @(posedge clk);
        $display("Checked %0d words: directed extremes in both modes, %0d random phases",
                 checked, N_PHASES);
        $display("with extreme, folded and random angles.");
        if (errors == 0 && rot_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d words still expected", errors, rot_expected.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
